// ===== design/log_distance_score_unit_macros.svh =====
// Assertion macros for the log distance score unit.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef LOG_DISTANCE_SCORE_UNIT_MACROS_SVH
`define LOG_DISTANCE_SCORE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LDS_ASSERT_IMP(lbl, ante, cons, msg)
`define LDS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/ldsu_pkg.sv =====
// Shared types and constants for the log distance score unit.
// No dependencies; imported by ldsu_accum and log_distance_score_unit.
package ldsu_pkg;

  localparam int LOG_FRAC_BITS_DEF = 16;
  localparam int ELEM_W            = 16;
  localparam int SQ_W              = 33;
  localparam int SUM_W             = 48;
  localparam int MANT_W            = 32;
  localparam int EXP_W             = 6;
  localparam int CFG_W             = 24;
  localparam int SCORE_W           = 17;
  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;
  localparam logic [EXP_W-1:0]   EXP_TOP   = 6'd47;
  localparam logic [EXP_W-1:0]   EXP_BIAS  = 6'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_NORM,
    ST_SQUARE,
    ST_SCALE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
  } acc_ctl_t;

endpackage

// ===== design/ldsu_accum.sv =====
// Squared-difference stage and saturating 48-bit sum of squares.
// Depends on ldsu_pkg; driven by the sequencer in log_distance_score_unit.
module ldsu_accum (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ldsu_pkg::acc_ctl_t                  ctl,
  input  logic signed [ldsu_pkg::ELEM_W-1:0]  rep_element,
  input  logic signed [ldsu_pkg::ELEM_W-1:0]  sample_element,
  output logic        [ldsu_pkg::SUM_W-1:0]   sum_nxt
);
  import ldsu_pkg::*;

  logic signed [ELEM_W:0]   diff;
  logic        [ELEM_W:0]   abs_diff;
  logic        [2*ELEM_W+1:0] sq_full;
  logic        [SQ_W-1:0]   sq_r;
  logic                     pend_r;
  logic        [SUM_W-1:0]  sum_r;
  logic        [SUM_W:0]    sum_add;

  assign diff     = (ELEM_W+1)'(rep_element) - (ELEM_W+1)'(sample_element);
  assign abs_diff = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : (ELEM_W+1)'(diff);
  assign sq_full  = abs_diff * abs_diff;
  assign sum_add  = {1'b0, sum_r} + (SUM_W+1)'(sq_r);

  always_comb begin
    if (!pend_r) begin
      sum_nxt = sum_r;
    end else if (sum_add[SUM_W]) begin
      sum_nxt = '1;
    end else begin
      sum_nxt = sum_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      pend_r <= ctl.load;
      sum_r  <= ctl.clear ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
  end

endmodule

// ===== design/log_distance_score_unit.sv =====
// Log distance score unit: sum of squares, iterative log2 and scaling to Q1.16.
// Depends on ldsu_pkg, ldsu_accum and log_distance_score_unit_macros.svh.
//
//  channel | dir | tdata / tuser                               | transfer
//  in      | in  | rep_element, sample_element; tlast = last   | in_tvalid & in_tready
//  out     | out | score; tuser = zero_distance                | out_tvalid & out_tready
//  cfg     | in  | inv_log_range                               | cfg_wr_en
//
// After a non-last pair the next pair is accepted in the following cycle.
// A last pair steps through flush, normalize, LOG_FRAC_BITS squaring steps, scale and result
// (a zero sum skips squaring and scale); the one shared 32x32 multiplier squares the mantissa and scales the log.
// Input stays not ready until the result is loaded into the output register.
// A result waiting on out_tready does not block accepting further non-last pairs.
// Reset clears the sum, the sequencer, the output valid and inv_log_range.
`include "log_distance_score_unit_macros.svh"
module log_distance_score_unit #(
  parameter int LOG_FRAC_BITS = ldsu_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [15:0] rep_element, [31:16] sample_element
  input  logic                          in_tlast,   // last_element
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // [16:0] score, rest zero
  output logic                          out_tuser,  // [0] zero_distance
  input  logic                          cfg_wr_en,
  input  logic [ldsu_pkg::CFG_W-1:0]    cfg_wr_data
);
  import ldsu_pkg::*;

  localparam int CNT_W = $clog2(LOG_FRAC_BITS);
  localparam int N_W   = EXP_W - 1 + LOG_FRAC_BITS;

  state_t                   state_r, state_nxt;
  acc_ctl_t                 acc_ctl;
  logic                     in_fire;
  logic                     load_out;
  logic [SUM_W-1:0]         sum_nxt;
  logic [CFG_W-1:0]         inv_r;
  logic [SUM_W-1:0]         norm_r;
  logic [EXP_W-1:0]         e_r;
  logic                     zero_r;
  logic [MANT_W-1:0]        m_r;
  logic [LOG_FRAC_BITS-1:0] frac_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [2*MANT_W-1:0]      prod_r;
  logic [MANT_W-1:0]        mul_a, mul_b;
  logic [2*MANT_W-1:0]      mul_p;
  logic                     sq_bit;
  logic [N_W-1:0]           n_val;
  logic                     n_pos;
  logic [2*MANT_W-1:0]      scaled;
  logic [SCORE_W-1:0]       score_nxt;
  logic                     out_valid_r;
  logic [SCORE_W-1:0]       out_score_r;
  logic                     out_zero_r;
  logic                     last_iter;

  assign in_fire = in_tvalid && in_tready;

  ldsu_accum u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (acc_ctl),
    .rep_element    (in_tdata[15:0]),
    .sample_element (in_tdata[31:16]),
    .sum_nxt        (sum_nxt)
  );

  // shared multiplier: mantissa square or log scaling
  assign n_val = {(EXP_W-1)'(e_r - EXP_BIAS), frac_r};
  assign n_pos = (e_r > EXP_BIAS) || ((e_r == EXP_BIAS) && (frac_r != '0));
  always_comb begin
    if (state_r == ST_SQUARE) begin
      mul_a = m_r;
      mul_b = m_r;
    end else begin
      mul_a = MANT_W'(n_val);
      mul_b = MANT_W'(inv_r);
    end
  end
  assign mul_p  = mul_a * mul_b;
  assign sq_bit = mul_p[2*MANT_W-1];

  assign last_iter = (cnt_r == CNT_W'(LOG_FRAC_BITS - 1));
  assign scaled    = prod_r >> (LOG_FRAC_BITS + 8);

  always_comb begin
    if (zero_r || !n_pos) begin
      score_nxt = '0;
    end else if (scaled > (2*MANT_W)'(SCORE_ONE)) begin
      score_nxt = SCORE_ONE;
    end else begin
      score_nxt = scaled[SCORE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire && in_tlast) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_NORM;
      ST_NORM: begin
        if (norm_r == '0) begin
          state_nxt = ST_RESULT;
        end else if (norm_r[SUM_W-1]) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: if (last_iter) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_RESULT;
      ST_RESULT: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    acc_ctl.load  = in_fire;
    acc_ctl.clear = (state_r == ST_FLUSH);
    load_out      = (state_r == ST_RESULT) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      inv_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        inv_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_FLUSH: begin
        norm_r <= sum_nxt;
        e_r    <= EXP_TOP;
        zero_r <= 1'b0;
      end
      ST_NORM: begin
        if (norm_r == '0) begin
          zero_r <= 1'b1;
        end else if (norm_r[SUM_W-1]) begin
          m_r    <= norm_r[SUM_W-1 -: MANT_W];
          frac_r <= '0;
          cnt_r  <= '0;
        end else if (norm_r[SUM_W-1 -: 8] == '0) begin
          norm_r <= norm_r << 8;
          e_r    <= e_r - EXP_W'(8);
        end else begin
          norm_r <= norm_r << 1;
          e_r    <= e_r - EXP_W'(1);
        end
      end
      ST_SQUARE: begin
        m_r    <= sq_bit ? mul_p[2*MANT_W-1 -: MANT_W] : mul_p[2*MANT_W-2 -: MANT_W];
        frac_r <= {frac_r[LOG_FRAC_BITS-2:0], sq_bit};
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      ST_SCALE: prod_r <= mul_p;
      default: ;
    endcase
    if (load_out) begin
      out_score_r <= score_nxt;
      out_zero_r  <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_score_r};
  assign out_tuser  = out_zero_r;

  `LDS_ASSERT_IMP(a_zero_score, out_tvalid && out_tuser, out_tdata[16:0] == 17'd0, "zero distance with nonzero score")
  `LDS_ASSERT_IMP(a_score_range, out_tvalid, out_tdata[16:0] <= SCORE_ONE, "score above one")
  `LDS_ASSERT_NXT(a_last_stall, in_tvalid && in_tready && in_tlast, !in_tready, "input ready right after last transfer")

endmodule
